// File: hw/rtl/recoverable_compare_and_swap_unit_macros.svh
// assertion macros for the recoverable compare-and-swap unit
`ifndef RECOVERABLE_COMPARE_AND_SWAP_UNIT_MACROS_SVH
`define RECOVERABLE_COMPARE_AND_SWAP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define RCAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define RCAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RCAS_ASSERT_IMP(lbl, ante, cons, msg)
`define RCAS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/rcas_pkg.sv
// shared constants and types of the recoverable compare-and-swap unit
package rcas_pkg;

  localparam int DEF_MAX_THREADS = 8;
  localparam int DEF_NUM_WORDS   = 4;

  localparam int VALUE_W = 32;
  localparam int TID_W   = 3;
  localparam int WIDX_W  = 2;
  localparam int ACT_W   = 4;

  localparam logic [ACT_W-1:0] ACTIVE_THREADS_RESET = 4'd8;

  // register indexes
  localparam logic REG_ACTIVE_THREADS = 1'b0;

  // commands
  localparam logic CMD_SWAP    = 1'b0;
  localparam logic CMD_RECOVER = 1'b1;

  typedef struct packed {
    logic               has_writer;
    logic [TID_W-1:0]   writer;
    logic [VALUE_W-1:0] value;
  } word_t;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
  } slot_t;

endpackage

// File: hw/rtl/recoverable_compare_and_swap_unit.sv
// recoverable compare-and-swap unit: shared words, notify matrix and sequencer
`include "recoverable_compare_and_swap_unit_macros.svh"

// The unit keeps NUM_WORDS shared words, each holding its last writer and a
// 32-bit value, and serves one request at a time. A compare-and-swap
// (command 0) succeeds when the word holds compare_value; the previous
// writer is then notified by writing the old value into its slot for the
// requester in the word's notify matrix, and the word takes the requester
// and swap_value. A recovery (command 1) reports success if the word still
// holds the requester with swap_value, or if a valid slot in the requester's
// row of the matrix holds swap_value; otherwise it retries the swap. Requests
// whose thread_num is at or above min(active_threads, MAX_THREADS) fail and
// change nothing. All compares go through one 32-bit equality unit driven by
// a small sequencer, and the matrix lives in a memory with one write port and
// one registered read port, scanned one slot per cycle. A swap passes through
// the check, swap and done states; a recovery goes from check to a scan of
// the requester's row, up to the effective active thread count, then to swap
// if no slot matched and then to done, and goes straight from check to done
// when the word still carries the requester's own write. While the receiver
// holds back an earlier result, the sequencer waits in done. After reset the
// matrix valid bits are swept clear, one slot a cycle, over all
// NUM_WORDS * 2^(2*ceil(log2 MAX_THREADS)) slots (256 at the defaults)
// while no request is taken; configuration writes are served throughout.
// The result register lets a new request be taken while the previous result
// is still waiting to be collected.
module recoverable_compare_and_swap_unit #(
  parameter int MAX_THREADS = rcas_pkg::DEF_MAX_THREADS,
  parameter int NUM_WORDS   = rcas_pkg::DEF_NUM_WORDS
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic [rcas_pkg::WIDX_W-1:0]  word_index,
  input  logic [rcas_pkg::TID_W-1:0]   thread_num,
  input  logic [rcas_pkg::VALUE_W-1:0] compare_value,
  input  logic [rcas_pkg::VALUE_W-1:0] swap_value,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         success,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // index widths follow from the store sizes
  localparam int TW        = $clog2(MAX_THREADS);
  localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int AW        = WW + 2 * TW;
  localparam int MEM_DEPTH = NUM_WORDS * (1 << (2 * TW));
  localparam logic [AW-1:0] CLR_LAST = AW'(MEM_DEPTH - 1);

  // sequencer codes
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SWAP  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // configuration register
  logic [rcas_pkg::ACT_W-1:0] active_threads;

  // latched transaction
  logic                         cmd_q;
  logic [WW-1:0]                word_q;
  logic [rcas_pkg::TID_W-1:0]   tid_q;
  logic [rcas_pkg::VALUE_W-1:0] expv_q;
  logic [rcas_pkg::VALUE_W-1:0] newv_q;
  logic [rcas_pkg::ACT_W-1:0]   cnt_q;
  logic                         in_range_q;

  // scan position and result
  logic [rcas_pkg::ACT_W-1:0] k;
  logic [rcas_pkg::ACT_W-1:0] k_plus;
  logic                       res;

  logic [AW-1:0] clr_addr;

  rcas_pkg::word_t words [NUM_WORDS];
  rcas_pkg::word_t cur_word;

  // notify matrix memory, addressed {word, notified writer, notifying thread}
  rcas_pkg::slot_t mem [MEM_DEPTH];
  rcas_pkg::slot_t rd_q;
  rcas_pkg::slot_t mem_wdata;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  logic            mem_we;

  // the shared equality unit
  logic [rcas_pkg::VALUE_W-1:0] cmp_a;
  logic [rcas_pkg::VALUE_W-1:0] cmp_b;
  logic                         cmp_eq;

  // effective thread count seen at acceptance
  logic [7:0]                 act_wide;
  logic [7:0]                 max_wide;
  logic [rcas_pkg::ACT_W-1:0] eff_cnt;
  logic                       accept_in;
  logic                       take_out;
  logic                       own_hit;

  assign act_wide = {4'b0, active_threads};
  assign max_wide = 8'(MAX_THREADS);
  assign eff_cnt  = (act_wide < max_wide) ? active_threads : max_wide[rcas_pkg::ACT_W-1:0];

  assign in_stall  = (state != S_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign take_out  = out_valid && !out_stall;

  assign cur_word = words[word_q];
  assign k_plus   = k + 4'd1;

  // operand selection for the one comparator
  always_comb begin
    unique case (state)
      S_SCAN: begin
        cmp_a = rd_q.value;
        cmp_b = newv_q;
      end
      S_SWAP: begin
        cmp_a = cur_word.value;
        cmp_b = expv_q;
      end
      default: begin
        cmp_a = cur_word.value;
        cmp_b = newv_q;
      end
    endcase
  end

  assign cmp_eq = (cmp_a == cmp_b);

  // word still carries the requester's own write
  assign own_hit = cur_word.has_writer && (cur_word.writer == tid_q) && cmp_eq;

  // read address runs one slot ahead of the compare
  assign mem_raddr = {word_q, TW'(tid_q), (state == S_SCAN) ? TW'(k_plus) : TW'(4'd0)};

  // memory write: clearing sweep or notification of the previous writer
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_SWAP && cmp_eq && cur_word.has_writer) begin
      mem_we          = 1'b1;
      mem_waddr       = {word_q, TW'(cur_word.writer), TW'(tid_q)};
      mem_wdata.valid = 1'b1;
      mem_wdata.value = cur_word.value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == CLR_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        priority if (!in_range_q) state_next = S_DONE;
        else if (cmd_q == rcas_pkg::CMD_SWAP) state_next = S_SWAP;
        else if (own_hit) state_next = S_DONE;
        else state_next = S_SCAN;
      end
      S_SCAN: begin
        priority if (rd_q.valid && cmp_eq) state_next = S_DONE;
        else if (k_plus >= cnt_q) state_next = S_SWAP;
      end
      S_SWAP: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  // transaction capture, scan counter and result
  always_ff @(posedge clk) begin
    if (accept_in) begin
      cmd_q      <= command;
      word_q     <= WW'(word_index);
      tid_q      <= thread_num;
      expv_q     <= compare_value;
      newv_q     <= swap_value;
      cnt_q      <= eff_cnt;
      in_range_q <= ({5'b0, word_index} < 7'(NUM_WORDS)) && ({1'b0, thread_num} < eff_cnt);
    end
    unique case (state)
      S_CHECK: begin
        k   <= '0;
        res <= in_range_q && own_hit;
      end
      S_SCAN: begin
        k   <= k_plus;
        res <= rd_q.valid && cmp_eq;
      end
      S_SWAP: begin
        res <= cmp_eq;
      end
      default: begin
        k <= k;
      end
    endcase
  end

  // shared words: updated by a successful swap
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        words[i] <= '0;
      end
    end else if (state == S_SWAP && cmp_eq) begin
      words[word_q].has_writer <= 1'b1;
      words[word_q].writer     <= tid_q;
      words[word_q].value      <= newv_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (take_out) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) success <= res;
  end

  // configuration port, register index from the word address bit
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_threads <= rcas_pkg::ACTIVE_THREADS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == rcas_pkg::REG_ACTIVE_THREADS) begin
      active_threads <= pwdata[rcas_pkg::ACT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == rcas_pkg::REG_ACTIVE_THREADS) prdata = {28'b0, active_threads};
  end

  // checks
  `RCAS_ASSERT_NXT(a_busy_after_accept, accept_in, state != S_IDLE, "idle right after accept")
  `RCAS_ASSERT_IMP(a_notify_valid, mem_we && state != S_CLEAR, mem_wdata.valid, "notify without valid")
  `RCAS_ASSERT_IMP(a_scan_bound, state == S_SCAN, k < cnt_q, "scan past active count")
  `RCAS_ASSERT_NXT(a_result_from_done, !out_valid && state != S_DONE, !out_valid, "stray result")

endmodule
